@@ sv/assert_macros.svh @@
// Assertion macros shared by the framebuffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The condition must never hold at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);
// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ sv/ccf_pkg.sv @@
// Shared types and constants of the clipped character framebuffer.
`timescale 1ns / 1ps
package ccf_pkg;

	localparam int COORD_W    = 11;
	localparam int GEN_W      = 12;
	localparam int RECT_W     = 10;
	localparam int CHAR_W     = 8;
	localparam int FW_W       = 8;
	localparam int FH_W       = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam int CMD_DEPTH  = 2;
	localparam int RES_DEPTH  = 4;
	localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

	localparam logic [CHAR_W-1:0] RESET_BLANK  = 8'd32;
	localparam logic [FW_W-1:0]   RESET_WIDTH  = 8'd128;
	localparam logic [FH_W-1:0]   RESET_HEIGHT = 7'd64;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLANK_CODE   = 2'd2;

	typedef enum logic [1:0] {
		REQ_GET   = 2'd0,
		REQ_PUT   = 2'd1,
		REQ_RECT  = 2'd2,
		REQ_CLEAR = 2'd3
	} req_t;

	typedef struct packed {
		logic [FW_W-1:0]   frame_width;
		logic [FH_W-1:0]   frame_height;
		logic [CHAR_W-1:0] blank_code;
	} cfg_t;

	// Classified request; coordinates are two's complement, one bit wider than the ports.
	// A zero height skips the side columns, a zero width skips the top and bottom rows.
	typedef struct packed {
		req_t              kind;
		logic [GEN_W-1:0]  pos_x;
		logic [GEN_W-1:0]  pos_y;
		logic [GEN_W-1:0]  end_x;
		logic [GEN_W-1:0]  end_y;
		logic              no_sides;
		logic              no_edges;
		logic [CHAR_W-1:0] char_value;
	} cmd_t;

	typedef struct packed {
		logic [CHAR_W-1:0] read_value;
		logic              in_range;
	} res_t;

endpackage

@@ sv/ccf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ccf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old contents when the same address is written in that cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/ccf_fifo.sv @@
// Small show-ahead queue used between the framebuffer stages.
`timescale 1ns / 1ps
module ccf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty,
	output logic [CW-1:0]    count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign dout    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

endmodule

@@ sv/ccf_front.sv @@
// Front end: decodes incoming requests and queues them for the back end.
`timescale 1ns / 1ps
module ccf_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic [1:0]                    req_type,
	input  logic [ccf_pkg::COORD_W-1:0]   pos_x,
	input  logic [ccf_pkg::COORD_W-1:0]   pos_y,
	input  logic [ccf_pkg::RECT_W-1:0]    rect_width,
	input  logic [ccf_pkg::RECT_W-1:0]    rect_height,
	input  logic [ccf_pkg::CHAR_W-1:0]    char_value,
	output logic                          cmd_full,
	input  logic                          cmd_pop,
	output ccf_pkg::cmd_t                 cmd,
	output logic                          cmd_empty
);
	import ccf_pkg::*;

	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

	cmd_t                 cmd_in;
	logic [GEN_W-1:0]     x_ext;
	logic [GEN_W-1:0]     y_ext;
	logic [CMD_CNT_W-1:0] cmd_count;

	// Sign-extend by one bit so that the far corner of any rectangle fits.
	assign x_ext = {pos_x[COORD_W-1], pos_x};
	assign y_ext = {pos_y[COORD_W-1], pos_y};

	always_comb begin
		cmd_in.kind       = req_t'(req_type);
		cmd_in.pos_x      = x_ext;
		cmd_in.pos_y      = y_ext;
		cmd_in.end_x      = x_ext + GEN_W'(rect_width) - GEN_W'(1);
		cmd_in.end_y      = y_ext + GEN_W'(rect_height) - GEN_W'(1);
		cmd_in.no_sides   = (rect_height == '0);
		cmd_in.no_edges   = (rect_width == '0);
		cmd_in.char_value = char_value;
	end

	ccf_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.dout   (cmd),
		.empty  (cmd_empty),
		.count  (cmd_count)
	);

	logic unused_count;
	assign unused_count = ^cmd_count;

endmodule

@@ sv/ccf_back.sv @@
// Back end: cell sequencer, clipping, address pipeline and the cell store.
`timescale 1ns / 1ps
module ccf_back #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ccf_pkg::cfg_t                   cfg,
	input  ccf_pkg::cmd_t                   cmd,
	input  logic                            cmd_empty,
	output logic                            cmd_pop,
	input  logic [ccf_pkg::RES_CNT_W-1:0]   res_count,
	output logic                            res_push,
	output ccf_pkg::res_t                   res_data,
	output logic                            init_busy
);
	import ccf_pkg::*;

	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MW    = 2 * COORD_W;
	localparam int SUM_W = RES_CNT_W + 1;

	typedef enum logic [4:0] {
		S_INIT  = 5'b00001,
		S_IDLE  = 5'b00010,
		S_RECT  = 5'b00100,
		S_CLEAR = 5'b01000,
		S_TOKEN = 5'b10000
	} state_t;

	state_t state_q, state_d;

	logic [COORD_W-1:0] eff_w, eff_h;
	logic [AW-1:0]      init_q;

	// Rectangle walker
	logic [GEN_W-1:0]  rx_q, ry_q, rxe_q, rye_q, k_q, k_end;
	logic [CHAR_W-1:0] rc_q;
	logic              side_q, phase_q, edges_off_q;
	logic              rect_load, rect_last;

	// Clear walker
	logic [COORD_W-1:0] col_q, row_q;
	logic               clear_load, col_last, clear_last;

	// Cell issued this cycle
	logic              g_vld, g_wr, g_res, g_kill, g_hit;
	logic [GEN_W-1:0]  g_x, g_y;
	logic [CHAR_W-1:0] g_data;

	logic [SUM_W-1:0]  pending;
	logic              credit_ok;

	logic              res_s1, wen_s1, hit_s1;
	logic [MW-1:0]     mul_s1;
	logic [COORD_W-1:0] x_s1;
	logic [CHAR_W-1:0] data_s1;
	logic              res_s2, hit_s2;

	logic [MW-1:0]     addr_sum;
	logic [AW-1:0]     cell_addr;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CHAR_W-1:0] ram_wdata;
	logic [CHAR_W-1:0] ram_rdata;

	assign eff_w = (COORD_W'(cfg.frame_width) > COORD_W'(MAX_COLS)) ?
		COORD_W'(MAX_COLS) : COORD_W'(cfg.frame_width);
	assign eff_h = (COORD_W'(cfg.frame_height) > COORD_W'(MAX_ROWS)) ?
		COORD_W'(MAX_ROWS) : COORD_W'(cfg.frame_height);

	assign init_busy = (state_q == S_INIT);

	// A result-bearing cell may start only if the result queue will have room for it.
	assign pending   = SUM_W'(res_count) + SUM_W'(res_s1) + SUM_W'(res_s2);
	assign credit_ok = (pending < SUM_W'(RES_DEPTH));

	// The walk ends after the last row cell, or after the last side cell when the
	// rectangle has no top and bottom rows.
	assign k_end      = phase_q ? rxe_q : rye_q;
	assign rect_last  = side_q && (k_q == k_end) && (phase_q || edges_off_q);
	assign col_last   = (col_q == eff_w - COORD_W'(1));
	assign clear_last = col_last && (row_q == eff_h - COORD_W'(1));

	always_comb begin
		state_d    = state_q;
		cmd_pop    = 1'b0;
		rect_load  = 1'b0;
		clear_load = 1'b0;
		g_vld      = 1'b0;
		g_wr       = 1'b0;
		g_res      = 1'b0;
		g_kill     = 1'b0;
		g_x        = cmd.pos_x;
		g_y        = cmd.pos_y;
		g_data     = cmd.char_value;
		unique case (state_q)
			S_INIT: begin
				if (init_q == AW'(DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (!cmd_empty) begin
					unique case (cmd.kind)
						REQ_GET, REQ_PUT: begin
							if (credit_ok) begin
								cmd_pop = 1'b1;
								g_vld   = 1'b1;
								g_res   = 1'b1;
								g_wr    = (cmd.kind == REQ_PUT);
							end
						end
						REQ_RECT: begin
							cmd_pop   = 1'b1;
							rect_load = 1'b1;
							state_d   = (cmd.no_sides && cmd.no_edges) ? S_TOKEN : S_RECT;
						end
						REQ_CLEAR: begin
							cmd_pop    = 1'b1;
							clear_load = 1'b1;
							state_d    = (eff_w == '0 || eff_h == '0) ? S_TOKEN : S_CLEAR;
						end
						default: ;
					endcase
				end
			end
			S_RECT: begin
				g_vld  = 1'b1;
				g_wr   = 1'b1;
				g_data = rc_q;
				if (!phase_q) begin
					g_x = side_q ? rxe_q : rx_q;
					g_y = k_q;
				end else begin
					g_x = k_q;
					g_y = side_q ? rye_q : ry_q;
				end
				if (rect_last) begin
					state_d = S_TOKEN;
				end
			end
			S_CLEAR: begin
				g_vld  = 1'b1;
				g_wr   = 1'b1;
				g_data = cfg.blank_code;
				g_x    = GEN_W'(col_q);
				g_y    = GEN_W'(row_q);
				if (clear_last) begin
					state_d = S_TOKEN;
				end
			end
			S_TOKEN: begin
				if (credit_ok) begin
					g_vld   = 1'b1;
					g_res   = 1'b1;
					g_kill  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

	assign g_hit = !g_kill && !g_x[GEN_W-1] && (g_x[COORD_W-1:0] < eff_w) &&
		!g_y[GEN_W-1] && (g_y[COORD_W-1:0] < eff_h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_q      <= '0;
			side_q      <= 1'b0;
			phase_q     <= 1'b0;
			edges_off_q <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			res_s1      <= 1'b0;
			wen_s1      <= 1'b0;
			hit_s1      <= 1'b0;
			res_s2      <= 1'b0;
			hit_s2      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_INIT) begin
				init_q <= init_q + AW'(1);
			end
			if (rect_load) begin
				side_q      <= 1'b0;
				phase_q     <= cmd.no_sides;
				edges_off_q <= cmd.no_edges;
			end else if (state_q == S_RECT) begin
				side_q <= !side_q;
				if (side_q && k_q == k_end) begin
					phase_q <= 1'b1;
				end
			end
			if (clear_load) begin
				col_q <= '0;
				row_q <= '0;
			end else if (state_q == S_CLEAR) begin
				col_q <= col_last ? '0 : col_q + COORD_W'(1);
				if (col_last) begin
					row_q <= row_q + COORD_W'(1);
				end
			end
			res_s1 <= g_vld && g_res;
			wen_s1 <= g_vld && g_wr && g_hit;
			hit_s1 <= g_vld && g_hit;
			res_s2 <= res_s1;
			hit_s2 <= hit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rect_load) begin
			rx_q  <= cmd.pos_x;
			ry_q  <= cmd.pos_y;
			rxe_q <= cmd.end_x;
			rye_q <= cmd.end_y;
			rc_q  <= cmd.char_value;
			k_q   <= cmd.no_sides ? cmd.pos_x : cmd.pos_y;
		end else if (state_q == S_RECT && side_q) begin
			k_q <= (k_q == k_end) ? rx_q : k_q + GEN_W'(1);
		end
		mul_s1  <= MW'(g_y[COORD_W-1:0]) * MW'(eff_w);
		x_s1    <= g_x[COORD_W-1:0];
		data_s1 <= g_data;
	end

	// Row offset plus column; only meaningful for a cell inside the frame.
	assign addr_sum  = mul_s1 + MW'(x_s1);
	assign cell_addr = addr_sum[AW-1:0];

	assign ram_we    = init_busy || wen_s1;
	assign ram_waddr = init_busy ? init_q : cell_addr;
	assign ram_wdata = init_busy ? RESET_BLANK : data_s1;

	ccf_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cell_addr),
		.rdata (ram_rdata)
	);

	assign res_push            = res_s2;
	assign res_data.read_value = hit_s2 ? ram_rdata : cfg.blank_code;
	assign res_data.in_range   = hit_s2;

endmodule

@@ sv/clipped_char_framebuffer_unit.sv @@
// Top level of the clipped character framebuffer: config registers, front, back, result queue.
//
//  Channel   Direction  Handshake               Payload
//  --------  ---------  ----------------------  ---------------------------------------------
//  request   in         push / full             req_type pos_x pos_y rect_width rect_height
//                                               char_value
//  result    out        empty / pop             read_value in_range
//  config    in         cfg_wr_en (no stall)    cfg_addr cfg_wdata
//
// After reset the cell store is swept to the reset blank code, one cell per cycle; full
// stays high during the sweep, and configuration writes are taken.
// Get and put make one store access each, so back-to-back gets and puts sustain one
// request per cycle while the result queue has room for their results.
// A rect or a clear holds the back end while it writes its cells one at a time through the
// single store write port; a clear covers all W*H cells, with W and H the clamped frame size.
// The request queue keeps taking requests while results wait; a stalled result queue holds
// the back end only when it has no room for the next result.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module clipped_char_framebuffer_unit #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Request queue side
	input  logic                              push,
	output logic                              full,
	input  logic [1:0]                        req_type,
	input  logic signed [ccf_pkg::COORD_W-1:0] pos_x,
	input  logic signed [ccf_pkg::COORD_W-1:0] pos_y,
	input  logic [ccf_pkg::RECT_W-1:0]        rect_width,
	input  logic [ccf_pkg::RECT_W-1:0]        rect_height,
	input  logic [ccf_pkg::CHAR_W-1:0]        char_value,
	// Result queue side
	output logic                              empty,
	input  logic                              pop,
	output logic [ccf_pkg::CHAR_W-1:0]        read_value,
	output logic                              in_range,
	// Configuration writes
	input  logic                              cfg_wr_en,
	input  logic [ccf_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [ccf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import ccf_pkg::*;

	cfg_t                 cfg_q;
	cmd_t                 cmd;
	res_t                 res_data, res_head;
	logic                 cmd_full, cmd_empty, cmd_pop;
	logic                 req_take;
	logic                 res_push, res_full;
	logic [RES_CNT_W-1:0] res_count;
	logic                 init_busy;

	// Configuration registers; writes to an unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= RESET_WIDTH;
			cfg_q.frame_height <= RESET_HEIGHT;
			cfg_q.blank_code   <= RESET_BLANK;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_wdata[FW_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_wdata[FH_W-1:0];
				REG_BLANK_CODE:   cfg_q.blank_code   <= cfg_wdata[CHAR_W-1:0];
				default: ;
			endcase
		end
	end

	// No request is taken while the store is still being swept after reset.
	assign full     = cmd_full || init_busy;
	assign req_take = push && !full;

	ccf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (req_take),
		.req_type    (req_type),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.char_value  (char_value),
		.cmd_full    (cmd_full),
		.cmd_pop     (cmd_pop),
		.cmd         (cmd),
		.cmd_empty   (cmd_empty)
	);

	ccf_back #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_count (res_count),
		.res_push  (res_push),
		.res_data  (res_data),
		.init_busy (init_busy)
	);

	// The back end reserves room here before it starts a result, so a push always lands.
	ccf_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_data),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_head),
		.empty  (empty),
		.count  (res_count)
	);

	assign read_value = res_head.read_value;
	assign in_range   = res_head.in_range;

	`ASSERT_NEVER(a_res_no_overflow, clk, arst_n, res_push && res_full, "result pushed into a full queue")
	`ASSERT_IMPLY(a_init_no_result, clk, arst_n, init_busy, !res_push && !cmd_pop, "back end active during store sweep")
	`ASSERT_IMPLY(a_pop_has_cmd, clk, arst_n, cmd_pop, !cmd_empty, "back end popped an empty request queue")

endmodule
